// File: rtl/core/tfvv_pkg.sv
// Shared types, constants and tables for the typed field value validator.
`timescale 1ns / 1ps
package tfvv_pkg;

    // Width of the running character counter
    localparam int COUNT_WIDTH = 16;
    // Width of the VARCHAR limit and of the reported count
    localparam int LIMIT_WIDTH = 16;
    // Common width for comparing the counter against the limit
    localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CMP_WIDTH-1:0] REPORT_MAX = CMP_WIDTH'({LIMIT_WIDTH{1'b1}});

    // Column type codes
    localparam logic [2:0] COL_NONE    = 3'd0;
    localparam logic [2:0] COL_INT     = 3'd1;
    localparam logic [2:0] COL_VARCHAR = 3'd2;
    localparam logic [2:0] COL_TEXT    = 3'd3;
    localparam logic [2:0] COL_FLOAT   = 3'd4;
    localparam logic [2:0] COL_DATE    = 3'd5;
    localparam logic [2:0] COL_BOOL    = 3'd6;
    localparam logic [2:0] COL_NONE_HI = 3'd7;

    // Characters of interest
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Date field layout and limits
    localparam logic [3:0] DATE_LENGTH    = 4'd10;
    localparam logic [7:0] DATE_MONTH_MAX = 8'd12;
    localparam logic [7:0] DATE_DAY_MAX   = 8'd31;
    localparam logic [7:0] DECIMAL_BASE   = 8'd10;

    // Boolean words: true, false, "1", "0" (lower case, zero padded)
    localparam int NUM_WORDS = 4;
    typedef logic [7:0] word_row_t [8];
    localparam word_row_t BOOL_WORDS [NUM_WORDS] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] BOOL_LENS [NUM_WORDS] = '{3'd4, 3'd5, 3'd1, 3'd1};

    // Running per-field check state
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] position;
        logic                   int_ok;
        logic                   float_ok;
        logic                   seen_digit;
        logic                   seen_point;
        logic                   date_ok;
        logic [3:0]             tens_digit;
        logic [NUM_WORDS-1:0]   word_candidates;
        logic                   over_limit;
    } field_state_t;

    localparam field_state_t FIELD_CLEAR = '{
        position:        '0,
        int_ok:          1'b1,
        float_ok:        1'b1,
        seen_digit:      1'b0,
        seen_point:      1'b0,
        date_ok:         1'b1,
        tens_digit:      4'd0,
        word_candidates: {NUM_WORDS{1'b1}},
        over_limit:      1'b0
    };

    // Verdict produced by the item that ends a field
    typedef struct packed {
        logic                   ends;
        logic                   is_valid;
        logic [LIMIT_WIDTH-1:0] char_count;
    } field_result_t;

endpackage

// File: rtl/core/typed_field_value_validator_unit.sv
// Top level of the typed field value validator: input register, check logic, result register.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready) carries one character of a text field per
//   transfer, tagged with the column type and the VARCHAR limit. last_char ends
//   the field; empty_field ends an empty field and its character is ignored.
//   Output channel (out_valid/out_ready) carries one verdict per field: is_valid
//   and the saturated character count.
// Timing
//   A character is captured in the input register on its transfer, the checks
//   run from that register, and an ending character then loads the result
//   register once it is free, and out_valid is driven from that register.
//   One character per cycle unless an ending one stalls; every stage holds one item.
// Stall
//   While out_ready is low and a verdict waits, characters that do not end a
//   field keep flowing into the running state. An ending character waits in the
//   input register until the result register frees, and in_ready drops then.
// Reset
//   rst_n clears both valid flags and returns the running state to the start
//   of a field. No clearing pass is needed.
module typed_field_value_validator_unit
    import tfvv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             char_byte,
    input  logic                   last_char,
    input  logic                   empty_field,
    input  logic [2:0]             value_type,
    input  logic [LIMIT_WIDTH-1:0] max_length,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   is_valid,
    output logic [LIMIT_WIDTH-1:0] char_count
);

    logic                   in_valid_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic                   empty_reg;
    logic [2:0]             type_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;

    field_state_t           state_reg;
    field_state_t           state_next;
    field_result_t          result;

    logic                   out_valid_reg;
    logic                   is_valid_reg;
    logic [LIMIT_WIDTH-1:0] count_reg;

    logic                   advance;
    logic                   out_free;

    tfvv_char_step u_step (
        .state       (state_reg),
        .char_byte   (char_reg),
        .last_char   (last_reg),
        .empty_field (empty_reg),
        .value_type  (type_reg),
        .max_length  (limit_reg),
        .state_next  (state_next),
        .result      (result)
    );

    // Handshake: an ending item needs room in the result register
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!result.ends || out_free);
    assign in_ready = !in_valid_reg || advance;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg  <= char_byte;
            last_reg  <= last_char;
            empty_reg <= empty_field;
            type_reg  <= value_type;
            limit_reg <= max_length;
        end
    end

    // Running field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIELD_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result.ends)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && result.ends)
        begin
            is_valid_reg <= result.is_valid;
            count_reg    <= result.char_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_valid   = is_valid_reg;
    assign char_count = count_reg;

endmodule

// File: rtl/core/tfvv_char_step.sv
// Per-character update of the field check state and the end-of-field verdict.
`timescale 1ns / 1ps
module tfvv_char_step
    import tfvv_pkg::*;
(
    input  field_state_t         state,
    input  logic [7:0]           char_byte,
    input  logic                 last_char,
    input  logic                 empty_field,
    input  logic [2:0]           value_type,
    input  logic [LIMIT_WIDTH-1:0] max_length,
    output field_state_t         state_next,
    output field_result_t        result
);

    logic                   digit;
    logic [3:0]             dval;
    logic                   at_start;
    logic                   lead_minus;
    logic [7:0]             lower;
    logic [7:0]             two_digit;
    logic [COUNT_WIDTH-1:0] pos;
    logic [CMP_WIDTH-1:0]   count_ext;
    field_state_t           upd;
    logic                   bool_hit;
    logic                   verdict;

    assign pos        = state.position;
    assign digit      = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    assign dval       = digit ? char_byte[3:0] : 4'd0;
    assign at_start   = (pos == '0);
    assign lead_minus = at_start && (char_byte == CHAR_MINUS);
    assign lower      = ((char_byte >= CHAR_UPPER_A) && (char_byte <= CHAR_UPPER_Z))
                        ? (char_byte + CASE_OFFSET) : char_byte;
    assign two_digit  = ({4'd0, state.tens_digit} * DECIMAL_BASE) + {4'd0, dval};

    // Running checks for one ordinary character
    always_comb
    begin
        upd = state;

        // INT: digits with an optional leading minus
        if (!(digit || lead_minus))
        begin
            upd.int_ok = 1'b0;
        end

        // FLOAT: digits, one point, optional leading minus
        if (!digit)
        begin
            if ((char_byte == CHAR_POINT) && !state.seen_point)
            begin
                upd.seen_point = 1'b1;
            end
            else if (!lead_minus)
            begin
                upd.float_ok = 1'b0;
            end
        end
        if (digit)
        begin
            upd.seen_digit = 1'b1;
        end

        // DATE: YYYY-MM-DD by position
        if (pos >= COUNT_WIDTH'(DATE_LENGTH))
        begin
            upd.date_ok = 1'b0;
        end
        else
        begin
            case (pos[3:0])
                4'd0, 4'd1, 4'd2, 4'd3:
                begin
                    if (!digit)
                    begin
                        upd.date_ok = 1'b0;
                    end
                end
                4'd4, 4'd7:
                begin
                    if (char_byte != CHAR_MINUS)
                    begin
                        upd.date_ok = 1'b0;
                    end
                end
                4'd5, 4'd8:
                begin
                    if (!digit)
                    begin
                        upd.date_ok = 1'b0;
                    end
                    upd.tens_digit = dval;
                end
                4'd6:
                begin
                    if (!digit || (two_digit == 8'd0) || (two_digit > DATE_MONTH_MAX))
                    begin
                        upd.date_ok = 1'b0;
                    end
                end
                4'd9:
                begin
                    if (!digit || (two_digit == 8'd0) || (two_digit > DATE_DAY_MAX))
                    begin
                        upd.date_ok = 1'b0;
                    end
                end
                default:
                begin
                    upd.date_ok = 1'b0;
                end
            endcase
        end

        // BOOLEAN: drop words that no longer match
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            if ((pos >= COUNT_WIDTH'(BOOL_LENS[k])) || (lower != BOOL_WORDS[k][pos[2:0]]))
            begin
                upd.word_candidates[k] = 1'b0;
            end
        end

        // VARCHAR: new length exceeds the limit
        if (CMP_WIDTH'(pos) >= CMP_WIDTH'(max_length))
        begin
            upd.over_limit = 1'b1;
        end

        // Saturating length counter
        if (pos != COUNT_MAX)
        begin
            upd.position = pos + 1'b1;
        end
    end

    // Boolean verdict on the updated state
    always_comb
    begin
        bool_hit = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            if (upd.word_candidates[k] && (upd.position == COUNT_WIDTH'(BOOL_LENS[k])))
            begin
                bool_hit = 1'b1;
            end
        end
    end

    // Verdict for the type carried by the ending character
    always_comb
    begin
        case (value_type)
            COL_INT:     verdict = upd.int_ok && upd.seen_digit;
            COL_VARCHAR: verdict = !upd.over_limit;
            COL_TEXT:    verdict = 1'b1;
            COL_FLOAT:   verdict = upd.float_ok && upd.seen_digit;
            COL_DATE:    verdict = upd.date_ok && (upd.position == COUNT_WIDTH'(DATE_LENGTH));
            COL_BOOL:    verdict = bool_hit;
            COL_NONE, COL_NONE_HI: verdict = 1'b0;
            default:     verdict = 1'b0;
        endcase
    end

    assign count_ext = CMP_WIDTH'(upd.position);

    // Empty marker, ending character, or plain update
    always_comb
    begin
        if (empty_field)
        begin
            state_next        = FIELD_CLEAR;
            result.ends       = 1'b1;
            result.is_valid   = (value_type == COL_VARCHAR) || (value_type == COL_TEXT);
            result.char_count = '0;
        end
        else
        begin
            state_next        = last_char ? FIELD_CLEAR : upd;
            result.ends       = last_char;
            result.is_valid   = verdict;
            result.char_count = (count_ext > REPORT_MAX) ? {LIMIT_WIDTH{1'b1}}
                                                         : count_ext[LIMIT_WIDTH-1:0];
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench for the typed field value validator: directed and random fields, scoreboard check.
`timescale 1ns / 1ps
module tb;
    import tfvv_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int ITEM_TARGET = 1050;
    localparam int TAIL_CYCLES = 20;

    typedef logic [7:0] text_q_t [$];

    // Running field state and queue of verdicts still owed by the block
    class field_verdict_board;
        field_state_t  fs;
        field_result_t pending_verdicts [$];
        int            errors;
        int            checked;
        int            valid_seen;

        function new();
            fs = FIELD_CLEAR;
            errors = 0;
            checked = 0;
            valid_seen = 0;
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH verdict %0d: %s got %0d expected %0d", checked, what, got, want);
        endtask

        // Is the field seen so far a valid value of type vt?
        function logic field_passes(logic [2:0] vt);
            logic ok;
            ok = 1'b0;
            case (vt)
                COL_INT:     ok = fs.int_ok && fs.seen_digit;
                COL_VARCHAR: ok = !fs.over_limit;
                COL_TEXT:    ok = 1'b1;
                COL_FLOAT:   ok = fs.float_ok && fs.seen_digit;
                COL_DATE:    ok = fs.date_ok && (fs.position == COUNT_WIDTH'(DATE_LENGTH));
                COL_BOOL:
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        if (fs.word_candidates[k] && fs.position == COUNT_WIDTH'(BOOL_LENS[k]))
                            ok = 1'b1;
                end
                default:     ok = 1'b0;
            endcase
            return ok;
        endfunction

        // Advance the running state by one accepted transfer
        function void note_char(logic [7:0] c, logic last, logic empty, logic [2:0] vt,
                                logic [LIMIT_WIDTH-1:0] lim);
            field_result_t          r;
            logic [COUNT_WIDTH-1:0] p;
            logic                   digit;
            logic [3:0]             d;
            logic [7:0]             lower;
            int                     n;
            r.ends = 1'b1;
            if (empty)
            begin
                fs = FIELD_CLEAR;
                r.is_valid = (vt == COL_VARCHAR) || (vt == COL_TEXT);
                r.char_count = '0;
                pending_verdicts.push_back(r);
                return;
            end
            p = fs.position;
            digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            d = digit ? 4'(c - CHAR_ZERO) : 4'd0;

            // INT: leading minus, then digits only
            if (!(digit || (p == 0 && c == CHAR_MINUS)))
                fs.int_ok = 1'b0;

            // FLOAT: one point allowed, leading minus allowed
            if (!digit)
            begin
                if (c == CHAR_POINT && !fs.seen_point)
                    fs.seen_point = 1'b1;
                else if (!(p == 0 && c == CHAR_MINUS))
                    fs.float_ok = 1'b0;
            end
            if (digit)
                fs.seen_digit = 1'b1;

            // DATE: YYYY-MM-DD with month and day range checks
            case (p)
                0, 1, 2, 3:
                    if (!digit) fs.date_ok = 1'b0;
                4, 7:
                    if (c != CHAR_MINUS) fs.date_ok = 1'b0;
                5, 8:
                begin
                    if (!digit) fs.date_ok = 1'b0;
                    fs.tens_digit = d;
                end
                6, 9:
                begin
                    n = int'(fs.tens_digit) * 10 + int'(d);
                    if (!digit || n < 1 || n > ((p == 6) ? 12 : 31))
                        fs.date_ok = 1'b0;
                end
                default:
                    fs.date_ok = 1'b0;
            endcase

            // BOOLEAN: knock out words that no longer match, case folded
            lower = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                if (fs.word_candidates[k])
                begin
                    if (p >= COUNT_WIDTH'(BOOL_LENS[k]))
                        fs.word_candidates[k] = 1'b0;
                    else if (lower != BOOL_WORDS[k][p[2:0]])
                        fs.word_candidates[k] = 1'b0;
                end
            end

            // VARCHAR: new length p+1 passes the limit when p >= limit
            if (CMP_WIDTH'(p) >= CMP_WIDTH'(lim))
                fs.over_limit = 1'b1;
            if (p != COUNT_MAX)
                fs.position = p + 1'b1;

            if (!last)
                return;
            r.is_valid = field_passes(vt);
            r.char_count = (CMP_WIDTH'(fs.position) > REPORT_MAX) ?
                           LIMIT_WIDTH'(REPORT_MAX) : LIMIT_WIDTH'(fs.position);
            pending_verdicts.push_back(r);
            fs = FIELD_CLEAR;
        endfunction

        // Compare one output transfer with the oldest owed verdict
        task check_verdict(logic got_valid, logic [LIMIT_WIDTH-1:0] got_count);
            field_result_t r;
            if (pending_verdicts.size() == 0)
            begin
                report("unexpected verdict, is_valid", got_valid, -1);
                return;
            end
            r = pending_verdicts.pop_front();
            if (got_valid !== r.is_valid)
                report("is_valid", got_valid, r.is_valid);
            if (got_count !== r.char_count)
                report("char_count", got_count, r.char_count);
            if (r.is_valid)
                valid_seen++;
            checked++;
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             char_byte;
    logic                   last_char;
    logic                   empty_field;
    logic [2:0]             value_type;
    logic [LIMIT_WIDTH-1:0] max_length;
    logic                   out_valid;
    logic                   out_ready;
    logic                   is_valid;
    logic [LIMIT_WIDTH-1:0] char_count;

    field_verdict_board board;
    int  chars_sent;
    int  fields_sent;
    int  drains;
    int  idle_cycles;
    bit  no_gaps;

    typed_field_value_validator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .last_char   (last_char),
        .empty_field (empty_field),
        .value_type  (value_type),
        .max_length  (max_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_valid    (is_valid),
        .char_count  (char_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: give up after a long stretch with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One input transfer, after a random gap unless gaps are off
    task automatic send_char(logic [7:0] c, logic last, logic empty, logic [2:0] vt,
                             logic [LIMIT_WIDTH-1:0] lim);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_byte   <= c;
        last_char   <= last;
        empty_field <= empty;
        value_type  <= vt;
        max_length  <= lim;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_char(c, last, empty, vt, lim);
        chars_sent++;
    endtask

    // Send a whole field; an empty text goes out as the empty-field marker.
    // drift varies type and limit inside the field; a stray empty marker may cut it short.
    task automatic send_field(text_q_t text, logic [2:0] vt, logic [LIMIT_WIDTH-1:0] lim,
                              bit drift, bit cuts);
        logic [2:0]             t;
        logic [LIMIT_WIDTH-1:0] l;
        fields_sent++;
        if (text.size() == 0)
        begin
            send_char(8'($urandom), 1'($urandom), 1'b1, vt, lim);
            return;
        end
        for (int i = 0; i < text.size(); i++)
        begin
            t = vt;
            l = lim;
            if (drift && $urandom_range(0, 3) == 0)
            begin
                t = 3'($urandom);
                l = LIMIT_WIDTH'($urandom);
            end
            if (cuts && i > 0 && $urandom_range(0, 39) == 0)
                send_char(8'($urandom), 1'($urandom), 1'b1, 3'($urandom), LIMIT_WIDTH'($urandom));
            send_char(text[i], i == text.size() - 1, 1'b0, t, l);
        end
    endtask

    // Hold the sender until the block has delivered every owed verdict
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge clk);
        drains++;
    endtask

    function automatic text_q_t to_text(string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] any_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Occasional damage so malformed values reach the block too
    function automatic void damage(ref text_q_t q);
        int pos;
        pos = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
        case ($urandom_range(0, 4))
            0: if (q.size() > 0) q[pos] = 8'($urandom);
            1: q.insert(pos, CHAR_POINT);
            2: q.insert(pos, CHAR_MINUS);
            3: if (q.size() > 1) q.delete(pos);
            default: q.push_back(any_digit());
        endcase
    endfunction

    // Signed decimal, with a point when asked
    function automatic text_q_t make_number(bit with_point);
        text_q_t q;
        int      n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            q.push_back(any_digit());
        if (with_point)
            q.insert($urandom_range(0, q.size()), CHAR_POINT);
        if ($urandom_range(0, 2) == 0)
            q.push_front(CHAR_MINUS);
        if ($urandom_range(0, 3) == 0)
            damage(q);
        if ($urandom_range(0, 19) == 0)
            q = to_text(with_point ? "-." : "-");
        return q;
    endfunction

    // YYYY-MM-DD with month and day mostly near their legal ranges
    function automatic text_q_t make_date();
        text_q_t q;
        for (int i = 0; i < 4; i++)
            q.push_back(any_digit());
        q.push_back(CHAR_MINUS);
        q.push_back(CHAR_ZERO + 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 9 : 1)));
        q.push_back(any_digit());
        q.push_back(CHAR_MINUS);
        q.push_back(CHAR_ZERO + 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 9 : 3)));
        q.push_back(any_digit());
        if ($urandom_range(0, 3) == 0)
            damage(q);
        return q;
    endfunction

    // One of the boolean words in random case, sometimes mangled
    function automatic text_q_t make_bool();
        text_q_t q;
        case ($urandom_range(0, 3))
            0: q = to_text("true");
            1: q = to_text("false");
            2: q = to_text("1");
            default: q = to_text("0");
        endcase
        foreach (q[i])
            if (q[i] > CHAR_NINE && $urandom_range(0, 1) == 1)
                q[i] = q[i] - CASE_OFFSET;
        case ($urandom_range(0, 7))
            0: if (q.size() > 1) q.delete(q.size() - 1);
            1: q.push_back(8'($urandom_range(8'h41, 8'h7A)));
            2: q = to_text("yes");
            default: ;
        endcase
        return q;
    endfunction

    // Arbitrary bytes, biased toward characters the checks care about
    function automatic text_q_t make_noise(int len);
        text_q_t q;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 5))
                0, 1: q.push_back(8'($urandom));
                2: q.push_back(any_digit());
                3: q.push_back(($urandom_range(0, 1) == 1) ? CHAR_MINUS : CHAR_POINT);
                4: q.push_back(8'h00);
                default: q.push_back(8'($urandom_range(8'h41, 8'h7A)));
            endcase
        end
        return q;
    endfunction

    // Receiver: random stalls, with calm stretches where it never stalls
    initial
    begin
        int stall;
        int calm;
        calm = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (calm > 0) ? 0 : $urandom_range(0, 12);
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 9) == 0)
                calm = $urandom_range(5, 25);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_verdict(is_valid, char_count);
        end
    end

    // Stimulus
    initial
    begin
        text_q_t                text;
        logic [2:0]             vt;
        logic [LIMIT_WIDTH-1:0] lim;
        int                     kind;
        board = new();
        chars_sent = 0;
        fields_sent = 0;
        drains = 0;
        no_gaps = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        char_byte   <= '0;
        last_char   <= 1'b0;
        empty_field <= 1'b0;
        value_type  <= COL_NONE;
        max_length  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each type at least once, limit extremes, empty field, zero and high bytes
        send_field(to_text("-7"), COL_INT, 16'd0, 0, 0);
        send_field(to_text("1.5"), COL_FLOAT, 16'hFFFF, 0, 0);
        send_field(to_text("2024-12-31"), COL_DATE, 16'd5, 0, 0);
        send_field(to_text("TrUe"), COL_BOOL, 16'd1, 0, 0);
        text.delete();
        send_field(text, COL_VARCHAR, 16'd0, 0, 0);
        send_field(to_text("x"), COL_VARCHAR, 16'd0, 0, 0);
        send_field(to_text("a"), COL_VARCHAR, 16'hFFFF, 0, 0);
        text = {8'h00};
        send_field(text, COL_TEXT, 16'd0, 0, 0);
        text = {8'hFF};
        send_field(text, COL_NONE_HI, 16'hFFFF, 0, 0);
        send_field(to_text("0"), COL_NONE, 16'd1, 0, 0);
        drain();

        // Random fields: mostly well-formed values of each type with random content
        while (chars_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 6);
            lim = LIMIT_WIDTH'($urandom);
            case (kind)
                0:
                begin
                    text = make_number(0);
                    vt = COL_INT;
                end
                1:
                begin
                    text = make_number(1);
                    vt = COL_FLOAT;
                end
                2:
                begin
                    text = make_date();
                    vt = COL_DATE;
                end
                3:
                begin
                    text = make_bool();
                    vt = COL_BOOL;
                end
                4:
                begin
                    text = make_noise(($urandom_range(0, 9) == 0) ?
                                      $urandom_range(20, 70) : $urandom_range(1, 12));
                    vt = COL_VARCHAR;
                    case ($urandom_range(0, 4))
                        0: lim = LIMIT_WIDTH'(text.size() - 1);
                        1: lim = LIMIT_WIDTH'(text.size());
                        2: lim = LIMIT_WIDTH'(text.size() + 1);
                        3: lim = '0;
                        default: ;
                    endcase
                end
                5:
                begin
                    text = make_noise($urandom_range(1, 12));
                    vt = ($urandom_range(0, 1) == 1) ? COL_TEXT : COL_NONE;
                end
                default:
                begin
                    text.delete();
                    vt = 3'($urandom);
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                vt = 3'($urandom);
            no_gaps = ($urandom_range(0, 4) == 0);
            send_field(text, vt, lim, $urandom_range(0, 7) == 0, 1'b1);
            if (fields_sent % 120 == 0)
                drain();
        end

        // Wind down: wait for every owed verdict, then let the pipeline settle
        in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d fields of all eight type codes, %0d drains.",
                 chars_sent, fields_sent, drains);
        $display("Checked %0d verdicts (%0d valid) under random stalls on both channels.",
                 board.checked, board.valid_seen);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
